[rtl/core/lprs_pkg.sv]
// Shared types for the length-prefixed record store: codes, states, commands and flags.
package lprs_pkg;

    typedef enum logic [2:0] {
        ACT_INIT   = 3'd0,
        ACT_COUNT  = 3'd1,
        ACT_WSTART = 3'd2,
        ACT_WBYTE  = 3'd3,
        ACT_READ   = 3'd4
    } act_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_INDEX = 3'd1,
        ST_LIMIT     = 3'd2,
        ST_NO_SPACE  = 3'd3,
        ST_INVALID   = 3'd4
    } st_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_CNT_RD,
        S_CNT_CHK,
        S_WS_CHK,
        S_WS_NLEN,
        S_WW_CHK,
        S_WW_DATA,
        S_WW_PAD1,
        S_WS_FIRST,
        S_WS_SCAN_RD,
        S_WS_SCAN,
        S_WS_FIT,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_WS_COMMIT,
        S_RD_CHK,
        S_RW_CHK,
        S_RW_DATA,
        S_RB_CHK,
        S_RB_DATA
    } ctl_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_INIT,
        OP_LOAD,
        OP_LOAD_WS,
        OP_WBYTE,
        OP_RD,
        OP_STEP,
        OP_WALK_INIT,
        OP_PAD0,
        OP_PAD1,
        OP_RD_TARGET,
        OP_SCAN_FIRST,
        OP_SCAN,
        OP_WR_TERM,
        OP_UP_INIT,
        OP_DN_INIT,
        OP_CP_RD,
        OP_UP_WR,
        OP_DN_WR,
        OP_COMMIT,
        OP_LEN,
        OP_RD_BYTE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   res_en;
        st_t    res_status;
        logic   res_count;
        logic   res_len;
        logic   res_byte;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic pos_out;
        logic is_end;
        logic step_over;
        logic idx_zero;
        logic limit_on;
        logic limit_hit;
        logic nlen_end;
        logic cnt_lt_idx;
        logic pad_over;
        logic nfit_over;
        logic at_term;
        logic grow;
        logic shrink;
        logic shift_over;
        logic ptr_lo;
        logic ptr_term;
        logic off_ok;
    } dp_flags_t;

endpackage

[rtl/core/lprs_ctrl.sv]
// Controller state machine that sequences every action over the datapath.
module lprs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2:0]          action,
    input  lprs_pkg::dp_flags_t flags,
    output lprs_pkg::dp_cmd_t   cmd,
    output logic                busy
);

    lprs_pkg::ctl_state_t state_reg;
    lprs_pkg::ctl_state_t state_next;
    lprs_pkg::act_t       act_reg;
    lprs_pkg::act_t       act_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lprs_pkg::S_CLEAR;
            act_reg   <= lprs_pkg::ACT_INIT;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
        end
    end

    assign busy = (state_reg != lprs_pkg::S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        cmd.op         = lprs_pkg::OP_NONE;
        cmd.res_en     = 1'b0;
        cmd.res_status = lprs_pkg::ST_OK;
        cmd.res_count  = 1'b0;
        cmd.res_len    = 1'b0;
        cmd.res_byte   = 1'b0;
        unique case (state_reg)
            lprs_pkg::S_CLEAR:
            begin
                cmd.op = lprs_pkg::OP_CLEAR;
                if (flags.clr_last)
                begin
                    state_next = lprs_pkg::S_IDLE;
                end
            end
            lprs_pkg::S_IDLE:
            begin
                if (start)
                begin
                    act_next = lprs_pkg::act_t'(action);
                    case (lprs_pkg::act_t'(action))
                        lprs_pkg::ACT_INIT:
                        begin
                            cmd.op     = lprs_pkg::OP_INIT;
                            cmd.res_en = 1'b1;
                        end
                        lprs_pkg::ACT_COUNT:
                        begin
                            cmd.op     = lprs_pkg::OP_LOAD;
                            state_next = lprs_pkg::S_CNT_RD;
                        end
                        lprs_pkg::ACT_WSTART:
                        begin
                            cmd.op     = lprs_pkg::OP_LOAD_WS;
                            state_next = lprs_pkg::S_WS_CHK;
                        end
                        lprs_pkg::ACT_WBYTE:
                        begin
                            cmd.op     = lprs_pkg::OP_WBYTE;
                            cmd.res_en = 1'b1;
                        end
                        lprs_pkg::ACT_READ:
                        begin
                            cmd.op     = lprs_pkg::OP_LOAD;
                            state_next = lprs_pkg::S_RD_CHK;
                        end
                        default:
                        begin
                            cmd.res_en = 1'b1;
                        end
                    endcase
                end
            end
            lprs_pkg::S_CNT_RD:
            begin
                if (flags.pos_out)
                begin
                    if (act_reg == lprs_pkg::ACT_COUNT)
                    begin
                        cmd.res_en     = 1'b1;
                        cmd.res_status = lprs_pkg::ST_INVALID;
                        state_next     = lprs_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = lprs_pkg::S_WS_NLEN;
                    end
                end
                else
                begin
                    cmd.op     = lprs_pkg::OP_RD;
                    state_next = lprs_pkg::S_CNT_CHK;
                end
            end
            lprs_pkg::S_CNT_CHK:
            begin
                if (flags.is_end)
                begin
                    if (act_reg == lprs_pkg::ACT_COUNT)
                    begin
                        cmd.res_en    = 1'b1;
                        cmd.res_count = 1'b1;
                        state_next    = lprs_pkg::S_IDLE;
                    end
                    else if (flags.limit_hit)
                    begin
                        cmd.res_en     = 1'b1;
                        cmd.res_status = lprs_pkg::ST_LIMIT;
                        state_next     = lprs_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = lprs_pkg::S_WS_NLEN;
                    end
                end
                else if (flags.step_over)
                begin
                    if (act_reg == lprs_pkg::ACT_COUNT)
                    begin
                        cmd.res_en     = 1'b1;
                        cmd.res_status = lprs_pkg::ST_INVALID;
                        state_next     = lprs_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = lprs_pkg::S_WS_NLEN;
                    end
                end
                else
                begin
                    cmd.op     = lprs_pkg::OP_STEP;
                    state_next = lprs_pkg::S_CNT_RD;
                end
            end
            lprs_pkg::S_WS_CHK:
            begin
                if (flags.idx_zero)
                begin
                    cmd.res_en     = 1'b1;
                    cmd.res_status = lprs_pkg::ST_BAD_INDEX;
                    state_next     = lprs_pkg::S_IDLE;
                end
                else if (flags.limit_on)
                begin
                    state_next = lprs_pkg::S_CNT_RD;
                end
                else
                begin
                    state_next = lprs_pkg::S_WS_NLEN;
                end
            end
            lprs_pkg::S_WS_NLEN:
            begin
                if (flags.nlen_end)
                begin
                    cmd.res_en     = 1'b1;
                    cmd.res_status = lprs_pkg::ST_NO_SPACE;
                    state_next     = lprs_pkg::S_IDLE;
                end
                else
                begin
                    cmd.op     = lprs_pkg::OP_WALK_INIT;
                    state_next = lprs_pkg::S_WW_CHK;
                end
            end
            lprs_pkg::S_WW_CHK:
            begin
                if (flags.pos_out)
                begin
                    cmd.res_en     = 1'b1;
                    cmd.res_status = lprs_pkg::ST_INVALID;
                    state_next     = lprs_pkg::S_IDLE;
                end
                else if (flags.cnt_lt_idx)
                begin
                    cmd.op     = lprs_pkg::OP_RD;
                    state_next = lprs_pkg::S_WW_DATA;
                end
                else
                begin
                    cmd.op     = lprs_pkg::OP_RD_TARGET;
                    state_next = lprs_pkg::S_WS_FIRST;
                end
            end
            lprs_pkg::S_WW_DATA:
            begin
                if (flags.is_end)
                begin
                    if (flags.pad_over)
                    begin
                        cmd.res_en     = 1'b1;
                        cmd.res_status = lprs_pkg::ST_NO_SPACE;
                        state_next     = lprs_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.op     = lprs_pkg::OP_PAD0;
                        state_next = lprs_pkg::S_WW_PAD1;
                    end
                end
                else
                begin
                    cmd.op     = lprs_pkg::OP_STEP;
                    state_next = lprs_pkg::S_WW_CHK;
                end
            end
            lprs_pkg::S_WW_PAD1:
            begin
                cmd.op     = lprs_pkg::OP_PAD1;
                state_next = lprs_pkg::S_WW_CHK;
            end
            lprs_pkg::S_WS_FIRST:
            begin
                cmd.op = lprs_pkg::OP_SCAN_FIRST;
                state_next = flags.is_end ? lprs_pkg::S_WS_FIT : lprs_pkg::S_WS_SCAN_RD;
            end
            lprs_pkg::S_WS_SCAN_RD:
            begin
                if (flags.pos_out)
                begin
                    cmd.res_en     = 1'b1;
                    cmd.res_status = lprs_pkg::ST_INVALID;
                    state_next     = lprs_pkg::S_IDLE;
                end
                else
                begin
                    cmd.op     = lprs_pkg::OP_RD;
                    state_next = lprs_pkg::S_WS_SCAN;
                end
            end
            lprs_pkg::S_WS_SCAN:
            begin
                cmd.op = lprs_pkg::OP_SCAN;
                state_next = flags.is_end ? lprs_pkg::S_WS_FIT : lprs_pkg::S_WS_SCAN_RD;
            end
            lprs_pkg::S_WS_FIT:
            begin
                if (flags.nfit_over)
                begin
                    cmd.res_en     = 1'b1;
                    cmd.res_status = lprs_pkg::ST_NO_SPACE;
                    state_next     = lprs_pkg::S_IDLE;
                end
                else if (flags.at_term)
                begin
                    cmd.op     = lprs_pkg::OP_WR_TERM;
                    state_next = lprs_pkg::S_WS_COMMIT;
                end
                else if (flags.grow)
                begin
                    if (flags.shift_over)
                    begin
                        cmd.res_en     = 1'b1;
                        cmd.res_status = lprs_pkg::ST_NO_SPACE;
                        state_next     = lprs_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.op     = lprs_pkg::OP_UP_INIT;
                        state_next = lprs_pkg::S_UP_RD;
                    end
                end
                else if (flags.shrink)
                begin
                    cmd.op     = lprs_pkg::OP_DN_INIT;
                    state_next = lprs_pkg::S_DN_RD;
                end
                else
                begin
                    state_next = lprs_pkg::S_WS_COMMIT;
                end
            end
            lprs_pkg::S_UP_RD:
            begin
                cmd.op     = lprs_pkg::OP_CP_RD;
                state_next = lprs_pkg::S_UP_WR;
            end
            lprs_pkg::S_UP_WR:
            begin
                cmd.op = lprs_pkg::OP_UP_WR;
                state_next = flags.ptr_lo ? lprs_pkg::S_WS_COMMIT : lprs_pkg::S_UP_RD;
            end
            lprs_pkg::S_DN_RD:
            begin
                cmd.op     = lprs_pkg::OP_CP_RD;
                state_next = lprs_pkg::S_DN_WR;
            end
            lprs_pkg::S_DN_WR:
            begin
                cmd.op = lprs_pkg::OP_DN_WR;
                state_next = flags.ptr_term ? lprs_pkg::S_WS_COMMIT : lprs_pkg::S_DN_RD;
            end
            lprs_pkg::S_WS_COMMIT:
            begin
                cmd.op     = lprs_pkg::OP_COMMIT;
                cmd.res_en = 1'b1;
                state_next = lprs_pkg::S_IDLE;
            end
            lprs_pkg::S_RD_CHK:
            begin
                if (flags.idx_zero)
                begin
                    cmd.res_en     = 1'b1;
                    cmd.res_status = lprs_pkg::ST_BAD_INDEX;
                    state_next     = lprs_pkg::S_IDLE;
                end
                else
                begin
                    state_next = lprs_pkg::S_RW_CHK;
                end
            end
            lprs_pkg::S_RW_CHK:
            begin
                cmd.op     = lprs_pkg::OP_RD;
                state_next = lprs_pkg::S_RW_DATA;
            end
            lprs_pkg::S_RW_DATA:
            begin
                if (flags.is_end)
                begin
                    cmd.res_en     = 1'b1;
                    cmd.res_status = lprs_pkg::ST_BAD_INDEX;
                    state_next     = lprs_pkg::S_IDLE;
                end
                else if (flags.cnt_lt_idx)
                begin
                    if (flags.step_over)
                    begin
                        cmd.res_en     = 1'b1;
                        cmd.res_status = lprs_pkg::ST_INVALID;
                        state_next     = lprs_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.op     = lprs_pkg::OP_STEP;
                        state_next = lprs_pkg::S_RW_CHK;
                    end
                end
                else
                begin
                    cmd.op     = lprs_pkg::OP_LEN;
                    state_next = lprs_pkg::S_RB_CHK;
                end
            end
            lprs_pkg::S_RB_CHK:
            begin
                if (flags.off_ok)
                begin
                    cmd.op     = lprs_pkg::OP_RD_BYTE;
                    state_next = lprs_pkg::S_RB_DATA;
                end
                else
                begin
                    cmd.res_en  = 1'b1;
                    cmd.res_len = 1'b1;
                    state_next  = lprs_pkg::S_IDLE;
                end
            end
            lprs_pkg::S_RB_DATA:
            begin
                cmd.res_en   = 1'b1;
                cmd.res_len  = 1'b1;
                cmd.res_byte = 1'b1;
                state_next   = lprs_pkg::S_IDLE;
            end
            default:
            begin
                state_next = lprs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/lprs_datapath.sv]
// Datapath: byte memory, walk pointers, fill state, limit register and result registers.
module lprs_datapath #(
    parameter int MEM_BYTES = 1024,
    parameter int END_MARK  = 255
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lprs_pkg::dp_cmd_t   cmd,
    output lprs_pkg::dp_flags_t flags,
    input  logic [7:0]          record_index,
    input  logic [7:0]          new_length,
    input  logic [7:0]          byte_value,
    input  logic [7:0]          byte_offset,
    input  logic                cfg_valid,
    input  logic [7:0]          cfg_data,
    output logic                done,
    output logic [2:0]          status,
    output logic [9:0]          record_count,
    output logic [7:0]          record_length,
    output logic [7:0]          data_byte
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam int PW = ((AW > 8) ? AW : 8) + 1;
    localparam logic [PW-1:0] MEM_P = PW'(MEM_BYTES);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BYTES - 1);
    localparam logic [7:0] END_B = 8'(END_MARK);

    logic [7:0]    mem [MEM_BYTES];
    logic [7:0]    rd_data_reg;

    logic [AW-1:0] clr_reg;
    logic [PW-1:0] fill_addr_reg;
    logic [7:0]    fill_rem_reg;
    logic [7:0]    max_reg;
    logic          done_reg;

    logic [PW-1:0] pos_reg;
    logic [PW-1:0] n_reg;
    logic [7:0]    cnt_reg;
    logic [7:0]    idx_reg;
    logic [7:0]    nlen_reg;
    logic [7:0]    off_reg;
    logic [PW-1:0] target_reg;
    logic [PW-1:0] term_reg;
    logic [7:0]    old_len_reg;
    logic [PW-1:0] ptr_reg;
    logic [7:0]    sh_reg;
    logic [7:0]    len_reg;

    lprs_pkg::st_t res_status_reg;
    logic [9:0]    res_count_reg;
    logic [7:0]    res_len_reg;
    logic [7:0]    res_byte_reg;

    logic [PW-1:0] step_pos;
    logic [PW-1:0] lo_pos;
    logic [PW-1:0] byte_addr;
    logic [PW-1:0] term_wr_addr;
    logic [7:0]    sh_up;
    logic          fill_ok;

    logic          we;
    logic [PW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [PW-1:0] raddr;

    assign step_pos     = pos_reg + PW'(rd_data_reg) + PW'(1);
    assign lo_pos       = target_reg + PW'(old_len_reg) + PW'(1);
    assign byte_addr    = pos_reg + PW'(off_reg) + PW'(1);
    assign term_wr_addr = target_reg + PW'(nlen_reg) + PW'(1);
    assign sh_up        = nlen_reg - old_len_reg;
    assign fill_ok      = (fill_rem_reg != 8'd0) && (fill_addr_reg < MEM_P);

    always_comb
    begin
        flags.clr_last   = (clr_reg == CLR_LAST);
        flags.pos_out    = (pos_reg >= MEM_P);
        flags.is_end     = (rd_data_reg == END_B);
        flags.step_over  = (step_pos >= MEM_P);
        flags.idx_zero   = (idx_reg == 8'd0);
        flags.limit_on   = (max_reg != 8'd0);
        flags.limit_hit  = (max_reg != 8'd0) && (n_reg >= PW'(max_reg))
                           && (PW'(idx_reg) > n_reg);
        flags.nlen_end   = (nlen_reg == END_B);
        flags.cnt_lt_idx = (cnt_reg < idx_reg);
        flags.pad_over   = ((pos_reg + PW'(1)) >= MEM_P);
        flags.nfit_over  = (term_wr_addr >= MEM_P);
        flags.at_term    = (target_reg == term_reg);
        flags.grow       = (nlen_reg > old_len_reg);
        flags.shrink     = (nlen_reg < old_len_reg);
        flags.shift_over = ((term_reg + PW'(sh_up)) >= MEM_P);
        flags.ptr_lo     = (ptr_reg == lo_pos);
        flags.ptr_term   = (ptr_reg == term_reg);
        flags.off_ok     = (off_reg < len_reg) && (byte_addr < MEM_P);
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = 8'd0;
        re    = 1'b0;
        raddr = pos_reg;
        case (cmd.op)
            lprs_pkg::OP_CLEAR:
            begin
                we    = 1'b1;
                waddr = PW'(clr_reg);
                wdata = (clr_reg == '0) ? END_B : 8'd0;
            end
            lprs_pkg::OP_INIT:
            begin
                we    = 1'b1;
                wdata = END_B;
            end
            lprs_pkg::OP_WBYTE:
            begin
                we    = fill_ok;
                waddr = fill_addr_reg;
                wdata = byte_value;
            end
            lprs_pkg::OP_RD, lprs_pkg::OP_RD_TARGET:
            begin
                re = 1'b1;
            end
            lprs_pkg::OP_CP_RD:
            begin
                re    = 1'b1;
                raddr = ptr_reg;
            end
            lprs_pkg::OP_RD_BYTE:
            begin
                re    = 1'b1;
                raddr = byte_addr;
            end
            lprs_pkg::OP_PAD0:
            begin
                we    = 1'b1;
                waddr = pos_reg;
            end
            lprs_pkg::OP_PAD1:
            begin
                we    = 1'b1;
                waddr = pos_reg + PW'(1);
                wdata = END_B;
            end
            lprs_pkg::OP_WR_TERM:
            begin
                we    = 1'b1;
                waddr = term_wr_addr;
                wdata = END_B;
            end
            lprs_pkg::OP_UP_WR:
            begin
                we    = 1'b1;
                waddr = ptr_reg + PW'(sh_reg);
                wdata = rd_data_reg;
            end
            lprs_pkg::OP_DN_WR:
            begin
                we    = 1'b1;
                waddr = ptr_reg - PW'(sh_reg);
                wdata = rd_data_reg;
            end
            lprs_pkg::OP_COMMIT:
            begin
                we    = 1'b1;
                waddr = target_reg;
                wdata = nlen_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr[AW-1:0]] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            fill_addr_reg <= '0;
            fill_rem_reg  <= 8'd0;
            max_reg       <= 8'd0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.res_en;
            if (cfg_valid)
            begin
                max_reg <= cfg_data;
            end
            case (cmd.op)
                lprs_pkg::OP_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                end
                lprs_pkg::OP_INIT, lprs_pkg::OP_LOAD_WS:
                begin
                    fill_rem_reg <= 8'd0;
                end
                lprs_pkg::OP_WBYTE:
                begin
                    if (fill_ok)
                    begin
                        fill_addr_reg <= fill_addr_reg + PW'(1);
                        fill_rem_reg  <= fill_rem_reg - 8'd1;
                    end
                end
                lprs_pkg::OP_COMMIT:
                begin
                    fill_addr_reg <= target_reg + PW'(1);
                    fill_rem_reg  <= nlen_reg;
                end
                default:
                begin
                    fill_rem_reg <= fill_rem_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            lprs_pkg::OP_LOAD, lprs_pkg::OP_LOAD_WS:
            begin
                idx_reg  <= record_index;
                nlen_reg <= new_length;
                off_reg  <= byte_offset;
                pos_reg  <= '0;
                n_reg    <= '0;
                cnt_reg  <= 8'd1;
            end
            lprs_pkg::OP_WALK_INIT:
            begin
                pos_reg <= '0;
                cnt_reg <= 8'd1;
            end
            lprs_pkg::OP_STEP:
            begin
                pos_reg <= step_pos;
                n_reg   <= n_reg + PW'(1);
                cnt_reg <= cnt_reg + 8'd1;
            end
            lprs_pkg::OP_PAD1:
            begin
                pos_reg <= pos_reg + PW'(1);
                cnt_reg <= cnt_reg + 8'd1;
            end
            lprs_pkg::OP_RD_TARGET:
            begin
                target_reg <= pos_reg;
            end
            lprs_pkg::OP_SCAN_FIRST, lprs_pkg::OP_SCAN:
            begin
                if (cmd.op == lprs_pkg::OP_SCAN_FIRST)
                begin
                    old_len_reg <= rd_data_reg;
                end
                if (rd_data_reg == END_B)
                begin
                    term_reg <= pos_reg;
                end
                else
                begin
                    pos_reg <= step_pos;
                end
            end
            lprs_pkg::OP_UP_INIT:
            begin
                ptr_reg <= term_reg;
                sh_reg  <= sh_up;
            end
            lprs_pkg::OP_DN_INIT:
            begin
                ptr_reg <= lo_pos;
                sh_reg  <= old_len_reg - nlen_reg;
            end
            lprs_pkg::OP_UP_WR:
            begin
                if (ptr_reg != lo_pos)
                begin
                    ptr_reg <= ptr_reg - PW'(1);
                end
            end
            lprs_pkg::OP_DN_WR:
            begin
                ptr_reg <= ptr_reg + PW'(1);
            end
            lprs_pkg::OP_LEN:
            begin
                len_reg <= rd_data_reg;
            end
            default:
            begin
                pos_reg <= pos_reg;
            end
        endcase
        if (cmd.res_en)
        begin
            res_status_reg <= ((cmd.op == lprs_pkg::OP_WBYTE) && !fill_ok)
                              ? lprs_pkg::ST_NO_SPACE : cmd.res_status;
            res_count_reg  <= cmd.res_count ? 10'(n_reg) : 10'd0;
            res_len_reg    <= cmd.res_len ? len_reg : 8'd0;
            res_byte_reg   <= cmd.res_byte ? rd_data_reg : 8'd0;
        end
    end

    assign done          = done_reg;
    assign status        = res_status_reg;
    assign record_count  = res_count_reg;
    assign record_length = res_len_reg;
    assign data_byte     = res_byte_reg;

endmodule

[rtl/core/length_prefixed_record_store_unit.sv]
// Top level of the length-prefixed record store: controller plus datapath.
// Commands transfer when start is high and busy is low; the result shows for one cycle
// with done high and cannot be held off. After reset the block sweeps its byte memory
// once, with busy high, before it takes a command. Init, write_byte and the unused
// actions give their result the cycle after the transfer. Count walks the record chain
// by its length bytes. Read walks the chain to the indexed record, then reads its
// length and, when byte_offset lies within it, that byte. A write_start walks the chain,
// padding empty records up to the index, runs the limit count first when a limit is set,
// and moves the tail when the record changes length. The byte memory does one read or
// write per cycle. max_records may be written at any time while idle; cfg_ready is
// always high.
module length_prefixed_record_store_unit #(
    parameter int MEM_BYTES = 1024,
    parameter int END_MARK  = 255
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] action,
    input  logic [7:0] record_index,
    input  logic [7:0] new_length,
    input  logic [7:0] byte_value,
    input  logic [7:0] byte_offset,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    output logic       done,
    output logic [2:0] status,
    output logic [9:0] record_count,
    output logic [7:0] record_length,
    output logic [7:0] data_byte
);

    lprs_pkg::dp_cmd_t   cmd;
    lprs_pkg::dp_flags_t flags;

    assign cfg_ready = 1'b1;

    lprs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .flags  (flags),
        .cmd    (cmd),
        .busy   (busy)
    );

    lprs_datapath #(
        .MEM_BYTES (MEM_BYTES),
        .END_MARK  (END_MARK)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .flags         (flags),
        .record_index  (record_index),
        .new_length    (new_length),
        .byte_value    (byte_value),
        .byte_offset   (byte_offset),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .done          (done),
        .status        (status),
        .record_count  (record_count),
        .record_length (record_length),
        .data_byte     (data_byte)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == lprs_pkg::ACT_INIT || action == lprs_pkg::ACT_WBYTE))
        |=> done)
        else $error("single-cycle action gave no result");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != lprs_pkg::ST_OK)
        |-> (record_count == 10'd0 && record_length == 8'd0 && data_byte == 8'd0))
        else $error("failed result carries data");

endmodule
